### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define AMC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define AMC_ASSERT(lbl, clk, rstn, prop, msg)
`define AMC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

### hdl/amc_pkg.sv
// types and constants of the accumulator machine
`default_nettype none
package amc_pkg;
  localparam int unsigned AddrW = 7;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 6;

  localparam logic [OpW-1:0] OP_READ   = 6'd10;
  localparam logic [OpW-1:0] OP_WRITE  = 6'd11;
  localparam logic [OpW-1:0] OP_LOAD   = 6'd20;
  localparam logic [OpW-1:0] OP_STORE  = 6'd21;
  localparam logic [OpW-1:0] OP_ADD    = 6'd30;
  localparam logic [OpW-1:0] OP_SUB    = 6'd31;
  localparam logic [OpW-1:0] OP_DIV    = 6'd32;
  localparam logic [OpW-1:0] OP_MUL    = 6'd33;
  localparam logic [OpW-1:0] OP_BR     = 6'd40;
  localparam logic [OpW-1:0] OP_BRNEG  = 6'd41;
  localparam logic [OpW-1:0] OP_BRZERO = 6'd42;
  localparam logic [OpW-1:0] OP_HALT   = 6'd43;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_IGN  = 2'd2;

  localparam logic KIND_LOAD = 1'b0;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic ignore;
    logic fetch;
    logic dec_op;
    logic dec_opnd;
    logic opnd_rd;
    logic exec;
    logic div_start;
    logic div_wb;
    logic out_load;
  } amc_cmd_t;

  typedef struct packed {
    logic kind;
    logic halted;
    logic is_div;
    logic div_zero;
    logic div_done;
    logic out_free;
  } amc_sts_t;
endpackage
`default_nettype wire

### hdl/accumulator_machine_cpu.sv
// top level of the decimal accumulator machine
// input channel: in_valid_i/in_ready_o with opcode_i, address_i, value_i;
//   opcode 0 loads an in-range value_i into memory at address_i, opcode 1 runs the
//   instruction at the program counter, value_i feeding a read instruction
// output channel: out_valid_o/out_ready_i, one result per request with the
//   write value, halt flag, program counter, accumulator and status
// a load steps through dispatch, load and output states, an instruction through dispatch,
//   fetch, opcode and operand decode, operand read, execute (and divide) and output;
//   no request is taken until the result is loaded into the output register,
//   so the step sequencer and its bit-per-cycle divider set the rate
// a result waiting on a stalled receiver sits in the output register while
//   the next request is accepted and processed; that request's result holds
//   until the output register is taken
// reset clears the accumulator, program counter, halt flag and the memory
//   valid bits, so every word reads as zero until written
`default_nettype none
`include "assert_macros.svh"
module accumulator_machine_cpu #(
  parameter int unsigned MEM_WORDS = 100
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic [6:0]         address_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    write_valid_o,
  output logic signed [31:0]      write_value_o,
  output logic                    halted_o,
  output logic [6:0]              program_counter_o,
  output logic signed [31:0]      acc_value_o,
  output logic [1:0]              status_o
);
  amc_pkg::amc_cmd_t cmd;
  amc_pkg::amc_sts_t sts;

  amc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  amc_datapath #(
    .MemWords (MEM_WORDS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (opcode_i),
    .address_i         (address_i),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .write_valid_o     (write_valid_o),
    .write_value_o     (write_value_o),
    .halted_o          (halted_o),
    .program_counter_o (program_counter_o),
    .acc_value_o       (acc_value_o),
    .status_o          (status_o)
  );

  `AMC_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "request accepted while busy")
  `AMC_ASSERT(a_pc_range, clk_i, rst_ni, out_valid_o |-> (32'(program_counter_o) <= MEM_WORDS), "pc out of range")
  `AMC_ASSERT(a_run_pc, clk_i, rst_ni, (out_valid_o && !halted_o) |-> (32'(program_counter_o) < MEM_WORDS), "running past end without halt")
  `AMC_ASSERT(a_divz_nowrite, clk_i, rst_ni, (out_valid_o && status_o == amc_pkg::ST_DIVZ) |-> !write_valid_o, "write flagged on divide by zero")
endmodule
`default_nettype wire

### hdl/amc_divider.sv
// iterative signed 32-bit divider, one quotient bit per cycle
`default_nettype none
module amc_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);
  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q, den_q;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q[31:0], quo_q[31]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[31] ^ den_i[31];
      quo_q <= num_i[31] ? (~num_i + 32'd1) : num_i;
      den_q <= den_i[31] ? (~den_i + 32'd1) : den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (~quo_q + 32'd1) : quo_q;
endmodule
`default_nettype wire

### hdl/amc_datapath.sv
// memory, accumulator, program counter, decode and result registers
`default_nettype none
module amc_datapath #(
  parameter int unsigned MemWords = 100
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire amc_pkg::amc_cmd_t     cmd_i,
  output amc_pkg::amc_sts_t          sts_o,
  input  wire logic                  opcode_i,
  input  wire logic [6:0]            address_i,
  input  wire logic signed [31:0]    value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       write_valid_o,
  output logic signed [31:0]         write_value_o,
  output logic                       halted_o,
  output logic [6:0]                 program_counter_o,
  output logic signed [31:0]         acc_value_o,
  output logic [1:0]                 status_o
);
  logic [31:0]         mem [MemWords];
  logic [MemWords-1:0] vld_q;
  logic [31:0]         rd_data_q;
  logic                rd_vld_q;
  logic [31:0]         rdata;

  logic                kind_q;
  logic [6:0]          addr_q;
  logic [31:0]         value_q;
  logic [31:0]         acc_q, acc_d;
  logic [6:0]          pc_q, pc_d;
  logic                halt_q, halt_d;
  logic [12:0]         w13_q;
  logic [5:0]          op_q;
  logic [6:0]          opnd_q;
  logic                wvalid_q;
  logic [31:0]         wval_q;
  logic [1:0]          st_q;

  logic                out_valid_q;
  logic                owv_q, ohalt_q;
  logic [31:0]         owval_q, oacc_q;
  logic [6:0]          opc_q;
  logic [1:0]          ost_q;

  logic [6:0]          ra;
  logic                we;
  logic [6:0]          wa;
  logic [31:0]         wd;
  logic                in_rng;
  logic [12:0]         w13;
  logic [26:0]         prod;
  logic [6:0]          next_pc;
  logic                load_ok;
  logic                div_done;
  logic [31:0]         div_q;

  assign rdata = rd_vld_q ? rd_data_q : 32'd0;
  assign ra    = cmd_i.fetch ? pc_q : opnd_q;

  assign load_ok = ($signed(value_q) >= -32'sd9999) && ($signed(value_q) <= 32'sd9999)
                   && (32'(addr_q) < MemWords);

  always_comb begin
    we = 1'b0;
    wa = opnd_q;
    wd = acc_q;
    if (cmd_i.load_wr && load_ok) begin
      we = 1'b1;
      wa = addr_q;
      wd = value_q;
    end else if (cmd_i.exec && op_q == amc_pkg::OP_READ) begin
      we = 1'b1;
      wd = value_q;
    end else if (cmd_i.exec && op_q == amc_pkg::OP_STORE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd_i.fetch || cmd_i.opnd_rd) begin
      rd_data_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[wa] <= 1'b1;
      end
      if (cmd_i.fetch || cmd_i.opnd_rd) begin
        rd_vld_q <= vld_q[ra];
      end
    end
  end

  assign in_rng = !rdata[31] && (rdata < 32'd4400);
  assign w13    = in_rng ? rdata[12:0] : 13'd0;
  assign prod   = 27'(w13) * 27'd5243;

  amc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (rdata),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_comb begin
    acc_d   = acc_q;
    halt_d  = halt_q;
    next_pc = pc_q + 7'd1;
    if (cmd_i.exec) begin
      case (op_q)
        amc_pkg::OP_LOAD:   acc_d = rdata;
        amc_pkg::OP_ADD:    acc_d = acc_q + rdata;
        amc_pkg::OP_SUB:    acc_d = acc_q - rdata;
        amc_pkg::OP_MUL:    acc_d = 32'(acc_q * rdata);
        amc_pkg::OP_BR:     next_pc = opnd_q;
        amc_pkg::OP_BRNEG:  if (acc_q[31]) next_pc = opnd_q;
        amc_pkg::OP_BRZERO: if (acc_q == 32'd0) next_pc = opnd_q;
        amc_pkg::OP_HALT: begin
          halt_d  = 1'b1;
          next_pc = pc_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.div_wb) begin
      acc_d = div_q;
    end
    pc_d = next_pc;
    if (32'(next_pc) >= MemWords) begin
      pc_d   = 7'(MemWords);
      halt_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec || cmd_i.div_wb) begin
        acc_q  <= acc_d;
        pc_q   <= pc_d;
        halt_q <= halt_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= opcode_i;
      addr_q   <= address_i;
      value_q  <= value_i;
      wvalid_q <= 1'b0;
      wval_q   <= '0;
      st_q     <= amc_pkg::ST_OK;
    end
    if (cmd_i.load_wr && !load_ok) begin
      st_q <= amc_pkg::ST_IGN;
    end
    if (cmd_i.ignore) begin
      st_q <= amc_pkg::ST_IGN;
    end
    if (cmd_i.dec_op) begin
      w13_q <= w13;
      op_q  <= prod[24:19];
    end
    if (cmd_i.dec_opnd) begin
      opnd_q <= 7'(w13_q - 13'(op_q) * 13'd100);
    end
    if (cmd_i.exec && op_q == amc_pkg::OP_WRITE) begin
      wvalid_q <= 1'b1;
      wval_q   <= rdata;
    end
    if (cmd_i.exec && op_q == amc_pkg::OP_DIV) begin
      st_q <= amc_pkg::ST_DIVZ;
    end
    if (cmd_i.out_load) begin
      owv_q   <= wvalid_q;
      owval_q <= wval_q;
      ohalt_q <= halt_q;
      opc_q   <= pc_q;
      oacc_q  <= acc_q;
      ost_q   <= st_q;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.halted   = halt_q;
  assign sts_o.is_div   = op_q == amc_pkg::OP_DIV;
  assign sts_o.div_zero = rdata == 32'd0;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign write_valid_o     = owv_q;
  assign write_value_o     = owval_q;
  assign halted_o          = ohalt_q;
  assign program_counter_o = opc_q;
  assign acc_value_o       = oacc_q;
  assign status_o          = ost_q;
endmodule
`default_nettype wire

### hdl/amc_controller.sv
// sequencer that steps the datapath through load and execute requests
`default_nettype none
module amc_controller (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire amc_pkg::amc_sts_t sts_i,
  output amc_pkg::amc_cmd_t      cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LOAD, S_FETCH, S_DEC_OP, S_DEC_OPND,
    S_OPND_RD, S_EXEC, S_DIV, S_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.kind == amc_pkg::KIND_LOAD) begin
          state_d = S_LOAD;
        end else if (sts_i.halted) begin
          cmd_o.ignore = 1'b1;
          state_d      = S_OUT;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d       = S_OUT;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_DEC_OP;
      end
      S_DEC_OP: begin
        cmd_o.dec_op = 1'b1;
        state_d      = S_DEC_OPND;
      end
      S_DEC_OPND: begin
        cmd_o.dec_opnd = 1'b1;
        state_d        = S_OPND_RD;
      end
      S_OPND_RD: begin
        cmd_o.opnd_rd = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.is_div && !sts_i.div_zero) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_OUT;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_wb = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire
